FILE: hdl/pss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the proportional slice subframe scheduler.
// No dependencies; every other file in hdl/ imports this package.
package pss_pkg;

    localparam int TICK_W         = 14;
    localparam int SHARE_W        = 8;
    localparam int SLICE_W        = 2;
    localparam int OUTCOME_W      = 2;
    localparam int SHARE_REGS     = 4;
    localparam int NUM_SLICES_DEF = 4;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;
    localparam int REG_IDX_W      = APB_AW - 2;
    localparam int DIV_CNT_W      = $clog2(TICK_W + 1);

    // register map, index = paddr[APB_AW-1:2]
    localparam logic [REG_IDX_W-1:0] REG_SHARE_0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SHARE_1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SHARE_2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SHARE_3 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_PERIOD  = REG_IDX_W'(4);

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE     = 2'd0,
        OUT_UNSLICED = 2'd1,
        OUT_SLICE    = 2'd2
    } t_outcome;

    typedef enum logic [1:0] {
        DIV_GCD  = 2'd0,   // r_b mod r_a
        DIV_RED  = 2'd1,   // share[k] / gcd
        DIV_TICK = 2'd2    // tick mod period
    } t_div_sel;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] idx;
        logic [SHARE_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic               rb_clear;
        logic               load_a;
        logic               gcd_step;
        logic               gcd_done;
        logic               red_write;
        logic               set_first;
        logic               div_start;
        t_div_sel           div_sel;
        logic               emit;
        t_outcome           kind;
        logic [SLICE_W-1:0] k;
    } t_dp_cmd;

    typedef struct packed {
        logic share_wr;
        logic a_zero;
        logic b_zero;
        logic div_busy;
        logic rem_zero;
        logic alloc_valid;
        logic period_zero;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/pss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: tick words in, scheduling result words out.
// Depends on pss_pkg for field widths.
interface pss_tick_if;
    import pss_pkg::*;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_number;
    modport source (output valid, output tick_number, input ready);
    modport sink   (input valid, input tick_number, output ready);
endinterface

interface pss_result_if;
    import pss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic [SLICE_W-1:0]   slice_index;
    modport source (output valid, output outcome, output slice_index, input ready);
    modport sink   (input valid, input outcome, input slice_index, output ready);
endinterface

FILE: hdl/pss_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, shared restoring divider, GCD/reduction
// registers, sequence position and output register. Depends on pss_pkg.
module pss_dp #(
    parameter int NUM_SLICES = pss_pkg::NUM_SLICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pss_pkg::t_dp_cmd             i_cmd,
    input  pss_pkg::t_cfg_wr             i_cfg,
    input  logic [pss_pkg::REG_IDX_W-1:0] i_rd_idx,
    input  logic [pss_pkg::TICK_W-1:0]   i_tick_number,
    input  logic                         i_out_ready,
    output pss_pkg::t_dp_stat            o_stat,
    output logic [pss_pkg::APB_DW-1:0]   o_rd_data,
    output logic                         o_out_valid,
    output logic [pss_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [pss_pkg::SLICE_W-1:0]  o_slice_index
);
    import pss_pkg::*;

    localparam int ACTIVE = (NUM_SLICES < SHARE_REGS) ? NUM_SLICES : SHARE_REGS;

    logic [SHARE_W-1:0]   r_share [SHARE_REGS];
    logic [SHARE_W-1:0]   r_period;
    logic [SHARE_W-1:0]   r_red   [SHARE_REGS];
    logic [SLICE_W-1:0]   r_cur;
    logic [SHARE_W-1:0]   r_cnt;
    logic                 r_alloc;
    logic [SHARE_W-1:0]   r_a;
    logic [SHARE_W-1:0]   r_b;
    // divider: dividend shifts out at the top, quotient shifts in at the bottom
    logic [TICK_W-1:0]    r_dvd;
    logic [SHARE_W-1:0]   r_dvs;
    logic [SHARE_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic                 r_busy;
    logic                 r_out_valid;
    logic [OUTCOME_W-1:0] r_outcome;
    logic [SLICE_W-1:0]   r_slice;

    logic [SHARE_REGS-1:0] nz;
    logic [SHARE_W:0]      rem_shift;
    logic [SHARE_W:0]      rem_sub;
    logic                  q_bit;
    logic [TICK_W-1:0]     n_dvd;
    logic [SHARE_W-1:0]    n_dvs;
    logic [SHARE_W:0]      cnt_inc;
    logic                  out_free;
    logic                  share_wr;

    // next slice after s, wrapping, with a nonzero reduced share; s if none
    function automatic logic [SLICE_W-1:0] next_active(
        input logic [SLICE_W-1:0]    s,
        input logic [SHARE_REGS-1:0] nzv
    );
        logic [SLICE_W:0]   c;
        logic [SLICE_W-1:0] res;
        res = s;
        for (int k = ACTIVE; k >= 1; k--) begin
            c = {1'b0, s} + (SLICE_W + 1)'(k);
            if (c >= (SLICE_W + 1)'(ACTIVE)) begin
                c = c - (SLICE_W + 1)'(ACTIVE);
            end
            if (nzv[c[SLICE_W-1:0]]) begin
                res = c[SLICE_W-1:0];
            end
        end
        return res;
    endfunction

    always_comb begin
        for (int k = 0; k < SHARE_REGS; k++) begin
            nz[k] = (r_red[k] != '0);
        end
    end

    // one restoring step per cycle
    assign rem_shift = {r_rem, r_dvd[TICK_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_dvs};
    assign q_bit     = (rem_shift >= {1'b0, r_dvs});

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_GCD: begin
                n_dvd = TICK_W'(r_b);
                n_dvs = r_a;
            end
            DIV_RED: begin
                n_dvd = TICK_W'(r_share[i_cmd.k]);
                n_dvs = r_b;
            end
            DIV_TICK: begin
                n_dvd = i_tick_number;
                n_dvs = r_period;
            end
            default: begin
                n_dvd = '0;
                n_dvs = '0;
            end
        endcase
    end

    assign cnt_inc  = {1'b0, r_cnt} + (SHARE_W + 1)'(1);
    assign out_free = !r_out_valid || i_out_ready;
    assign share_wr = i_cfg.en && (i_cfg.idx < REG_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SHARE_REGS; k++) begin
                r_share[k] <= '0;
                r_red[k]   <= '0;
            end
            r_period    <= '0;
            r_cur       <= '0;
            r_cnt       <= '0;
            r_alloc     <= 1'b0;
            r_busy      <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration
            if (share_wr) begin
                r_share[i_cfg.idx[SLICE_W-1:0]] <= i_cfg.data;
            end else if (i_cfg.en && i_cfg.idx == REG_PERIOD) begin
                r_period <= i_cfg.data;
            end

            // rebuild of the reduced sequence
            if (i_cmd.rb_clear) begin
                for (int k = 0; k < SHARE_REGS; k++) begin
                    r_red[k] <= '0;
                end
                r_cur   <= '0;
                r_cnt   <= '0;
                r_alloc <= 1'b0;
                r_b     <= '0;
            end
            if (i_cmd.load_a) begin
                r_a <= r_share[i_cmd.k];
            end
            if (i_cmd.gcd_step) begin
                r_b <= r_a;
                r_a <= r_rem;
            end
            if (i_cmd.gcd_done) begin
                r_alloc <= (r_b != '0);
            end
            if (i_cmd.red_write) begin
                r_red[i_cmd.k] <= r_dvd[SHARE_W-1:0];
            end
            if (i_cmd.set_first) begin
                r_cur <= next_active(SLICE_W'(ACTIVE - 1), nz);
            end

            // divider
            if (i_cmd.div_start) begin
                r_dvd  <= n_dvd;
                r_dvs  <= n_dvs;
                r_rem  <= '0;
                r_dcnt <= DIV_CNT_W'(TICK_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= q_bit ? rem_sub[SHARE_W-1:0] : rem_shift[SHARE_W-1:0];
                r_dvd  <= {r_dvd[TICK_W-2:0], q_bit};
                r_dcnt <= r_dcnt - DIV_CNT_W'(1);
                r_busy <= (r_dcnt != DIV_CNT_W'(1));
            end

            // result word and sequence advance
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_outcome   <= i_cmd.kind;
                r_slice     <= (i_cmd.kind == OUT_SLICE) ? r_cur : '0;
                if (i_cmd.kind == OUT_SLICE) begin
                    if (cnt_inc >= {1'b0, r_red[r_cur]}) begin
                        r_cnt <= '0;
                        r_cur <= next_active(r_cur, nz);
                    end else begin
                        r_cnt <= cnt_inc[SHARE_W-1:0];
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_rd_data = '0;
        unique case (i_rd_idx)
            REG_SHARE_0: o_rd_data = APB_DW'(r_share[0]);
            REG_SHARE_1: o_rd_data = APB_DW'(r_share[1]);
            REG_SHARE_2: o_rd_data = APB_DW'(r_share[2]);
            REG_SHARE_3: o_rd_data = APB_DW'(r_share[3]);
            REG_PERIOD:  o_rd_data = APB_DW'(r_period);
            default:     o_rd_data = '0;
        endcase
    end

    assign o_stat.share_wr    = share_wr;
    assign o_stat.a_zero      = (r_a == '0);
    assign o_stat.b_zero      = (r_b == '0);
    assign o_stat.div_busy    = r_busy;
    assign o_stat.rem_zero    = (r_rem == '0);
    assign o_stat.alloc_valid = r_alloc;
    assign o_stat.period_zero = (r_period == '0);
    assign o_stat.out_free    = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_slice_index = r_slice;

endmodule

FILE: hdl/pss_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the GCD rebuild, the per-tick modulo and the result
// hand-off through command/status structs. Depends on pss_pkg.
module pss_ctrl #(
    parameter int NUM_SLICES = pss_pkg::NUM_SLICES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pss_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output pss_pkg::t_dp_cmd  o_cmd
);
    import pss_pkg::*;

    localparam int ACTIVE = (NUM_SLICES < SHARE_REGS) ? NUM_SLICES : SHARE_REGS;
    localparam logic [SLICE_W-1:0] LAST = SLICE_W'(ACTIVE - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RB_LOAD,
        S_RB_TEST,
        S_RB_DIV,
        S_RD_START,
        S_RD_WAIT,
        S_FIRST,
        S_TICK_DIV,
        S_EMIT
    } t_state;

    t_state             r_state, n_state;
    logic [SLICE_W-1:0] r_k, n_k;
    t_outcome           r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.k = r_k;
        if (i_stat.share_wr) begin
            // any share write restarts the rebuild
            o_cmd.rb_clear = 1'b1;
            n_k            = '0;
            n_state        = S_RB_LOAD;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (!i_stat.alloc_valid) begin
                            n_kind  = OUT_NONE;
                            n_state = S_EMIT;
                        end else if (!i_stat.period_zero) begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = DIV_TICK;
                            n_state         = S_TICK_DIV;
                        end else begin
                            n_kind  = OUT_SLICE;
                            n_state = S_EMIT;
                        end
                    end
                end
                S_RB_LOAD: begin
                    o_cmd.load_a = 1'b1;
                    n_state      = S_RB_TEST;
                end
                S_RB_TEST: begin
                    if (i_stat.a_zero) begin
                        if (r_k == LAST) begin
                            o_cmd.gcd_done = 1'b1;
                            if (i_stat.b_zero) begin
                                n_state = S_IDLE;
                            end else begin
                                n_k     = '0;
                                n_state = S_RD_START;
                            end
                        end else begin
                            n_k     = r_k + SLICE_W'(1);
                            n_state = S_RB_LOAD;
                        end
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_GCD;
                        n_state         = S_RB_DIV;
                    end
                end
                S_RB_DIV: begin
                    if (!i_stat.div_busy) begin
                        o_cmd.gcd_step = 1'b1;
                        n_state        = S_RB_TEST;
                    end
                end
                S_RD_START: begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_RED;
                    n_state         = S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    if (!i_stat.div_busy) begin
                        o_cmd.red_write = 1'b1;
                        if (r_k == LAST) begin
                            n_state = S_FIRST;
                        end else begin
                            n_k     = r_k + SLICE_W'(1);
                            n_state = S_RD_START;
                        end
                    end
                end
                S_FIRST: begin
                    o_cmd.set_first = 1'b1;
                    n_state         = S_IDLE;
                end
                S_TICK_DIV: begin
                    if (!i_stat.div_busy) begin
                        n_kind  = i_stat.rem_zero ? OUT_UNSLICED : OUT_SLICE;
                        n_state = S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = r_kind;
                        n_state    = S_IDLE;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_kind  <= OUT_NONE;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: hdl/proportional_slice_subframe_scheduler.sv
`timescale 1ns / 1ps
// Usage
//   i_tick (sink): one word per subframe tick, carrying tick_number.
//   o_result (source): one word per tick: outcome (none / unsliced / slice)
//     and slice_index, which is meaningful only for a slice outcome.
//   APB port: share_0..share_3 at 0x00..0x0C, unsliced_period at 0x10.
//     pready is tied high; writes land on the access cycle.
// Flow
//   One tick word in flight at a time. Without an unsliced period (or with
//   no allocation) the outcome is set in the idle state and registered out
//   from the emit state; with a period it waits in between on the 14-step
//   restoring divider that computes tick mod period.
// Share writes
//   A share write reloads the GCD reduction on the same shared divider:
//   Euclid steps (at most 12 per slice), a load and a test per slice and
//   one divide per slice. i_tick.ready stays low until it is done.
// Reset
//   Synchronous, active low: shares, period and reduced sequence zero, no allocation, no result.
// Stall
//   The result register holds its word while o_result.ready is low; the
//   next tick can be taken meanwhile and waits finished until it frees up.
// Depends on pss_pkg, pss_if, pss_ctrl and pss_dp.
module proportional_slice_subframe_scheduler #(
    parameter int NUM_SLICES = pss_pkg::NUM_SLICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pss_tick_if.sink                    i_tick,
    pss_result_if.source                o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pss_pkg::APB_AW-1:0]  paddr,
    input  logic [pss_pkg::APB_DW-1:0]  pwdata,
    output logic [pss_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import pss_pkg::*;

    t_cfg_wr  cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    // APB decode: a write commits on the access cycle (pready is always high)
    assign pready   = 1'b1;
    assign cfg.en   = psel && penable && pwrite;
    assign cfg.idx  = paddr[APB_AW-1:2];
    assign cfg.data = pwdata[SHARE_W-1:0];

    pss_ctrl #(
        .NUM_SLICES (NUM_SLICES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tick.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    pss_dp #(
        .NUM_SLICES (NUM_SLICES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_rd_idx      (paddr[APB_AW-1:2]),
        .i_tick_number (i_tick.tick_number),
        .i_out_ready   (o_result.ready),
        .o_stat        (stat),
        .o_rd_data     (prdata),
        .o_out_valid   (o_result.valid),
        .o_outcome     (o_result.outcome),
        .o_slice_index (o_result.slice_index)
    );

    assign i_tick.ready = in_ready;

endmodule

FILE: hdl/pss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the scheduler top level, attached by bind.
// Depends on pss_pkg and proportional_slice_subframe_scheduler.
module pss_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pss_pkg::OUTCOME_W-1:0] outcome,
    input logic [pss_pkg::SLICE_W-1:0]  slice_index,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic                         pready,
    input logic [pss_pkg::APB_AW-1:0]   paddr
);
    import pss_pkg::*;

    logic share_wr;
    assign share_wr = psel && penable && pwrite && pready &&
                      (paddr[APB_AW-1:2] < REG_PERIOD);

    // stalled result word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(outcome) && $stable(slice_index))
        else $error("result word changed while stalled");

    // only a slice outcome carries a slice index
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && outcome != OUT_SLICE |-> slice_index == '0)
        else $error("slice index set on a non-slice outcome");

    // share write starts a rebuild, so no tick is taken right after
    a_rebuild_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        share_wr |=> !in_ready)
        else $error("tick accepted during rebuild");

    // one tick at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second tick accepted back to back");

    // reset empties the result register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");

endmodule

bind proportional_slice_subframe_scheduler pss_checker u_pss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_tick.valid),
    .in_ready    (i_tick.ready),
    .out_valid   (o_result.valid),
    .out_ready   (o_result.ready),
    .outcome     (o_result.outcome),
    .slice_index (o_result.slice_index),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr)
);
